### sv/crc_pkg.sv
// ============================================================================
// crc_pkg
// Shared constants, types and helper functions for the crosswise
// repetition count test.
// ============================================================================
`default_nettype none

package crc_pkg;

    // Shape of the test bank.
    localparam int SHIFT_BYTES   = 5;
    localparam int TEST_COUNT    = 40;
    localparam int RUN_WIDTH     = 12;
    localparam int LITERAL_TESTS = 8;

    // Fixed field widths.
    localparam int SYM_W       = 8;
    localparam int CUT_W       = 12;
    localparam int MASK_W      = 40;
    localparam int LIT_CNT_W   = 4;
    localparam int CROSS_CNT_W = 6;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    // Derived sizes.
    localparam int NUM_BYTES   = (TEST_COUNT + 7) / 8;
    localparam int CROSS_SUM_W = $clog2(TEST_COUNT + 1);
    localparam int CMP_W       = (RUN_WIDTH > CUT_W) ? RUN_WIDTH : CUT_W;

    localparam logic [RUN_WIDTH-1:0] RUN_MAX  = {RUN_WIDTH{1'b1}};
    localparam logic [RUN_WIDTH-1:0] RUN_ONE  = RUN_WIDTH'(1);
    localparam logic [CUT_W-1:0]     CUTOFF_RESET = CUT_W'(32);

    // Register map, indexed by paddr[2].
    typedef enum logic [0:0] {
        REG_BASE_CUTOFF  = 1'b0,
        REG_CROSS_CUTOFF = 1'b1
    } reg_idx_t;

    typedef logic [TEST_COUNT-1:0] pattern_t;

    // Front to back hand-off.
    typedef struct packed {
        logic     valid;
        pattern_t pattern;
    } mid_t;

    // One finished result.
    typedef struct packed {
        logic                   pass;
        logic [MASK_W-1:0]      fail_mask;
        logic [LIT_CNT_W-1:0]   literal_fail_count;
        logic [CROSS_CNT_W-1:0] cross_fail_count;
        logic [LIT_CNT_W-1:0]   max_literal_failures;
        logic [CROSS_CNT_W-1:0] max_cross_failures;
    } result_t;

    // Byte 0 is the symbol, byte k is symbol XOR rotate-left(symbol, k).
    // Bits beyond the expansion read as zero.
    function automatic pattern_t expand(input logic [SYM_W-1:0] sym);
        pattern_t p;
        int       k;
        int       b;
        p = '0;
        for (int j = 0; j < TEST_COUNT; j++)
        begin
            k = j >> 3;
            b = j & 7;
            if (k == 0)
            begin
                p[j] = sym[b];
            end
            else if (k < SHIFT_BYTES && k < 8)
            begin
                p[j] = sym[b] ^ sym[(b - k) & 7];
            end
        end
        return p;
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

endpackage : crc_pkg

`default_nettype wire

### sv/crosswise_repetition_count_test.sv
// ============================================================================
// crosswise_repetition_count_test
// Repetition count health test over a bank of eight oscillator bits and
// their crosswise XOR combinations.
// ============================================================================
// Each accepted symbol is expanded into 40 test bits (the eight raw bits,
// then symbol XOR rotate-left by 1 to 4), and every test bit keeps its own
// run length; a run that reaches its cutoff flags a failure for that symbol.
// Exactly one result comes out per symbol, in order. The block takes one
// symbol per clock cycle for as long as results are drained at the same
// pace; on its way to the result ports a result passes the input queue,
// the run counter stage, which works on the head of the input queue and
// registers the fail vector, and the count stage, which writes the result
// queue. The rate is set by the run counter stage, which updates all 40
// counters at once.
// Cutoffs are written through the APB port (base_cutoff at 0x0,
// cross_cutoff at 0x4, 12 bits each, reset value 32) and should only be
// changed while no symbol is in flight. The first symbol after reset only
// seeds the runs and always passes.
// ============================================================================
`default_nettype none

module crosswise_repetition_count_test
    import crc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // APB configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    // Symbol input queue
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [SYM_W-1:0]       symbol,
    // Result queue
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        pass,
    output logic [MASK_W-1:0]           fail_mask,
    output logic [LIT_CNT_W-1:0]        literal_fail_count,
    output logic [CROSS_CNT_W-1:0]      cross_fail_count,
    output logic [LIT_CNT_W-1:0]        max_literal_failures,
    output logic [CROSS_CNT_W-1:0]      max_cross_failures
);

    logic [CUT_W-1:0] base_cutoff_reg;
    logic [CUT_W-1:0] cross_cutoff_reg;
    reg_idx_t         reg_idx;
    logic             cfg_write;
    mid_t             mid;
    logic             mid_pop;
    logic             res_full;
    logic             res_push;
    result_t          res;
    result_t          head;

    // Registers sit on word boundaries; address bit 2 picks the register.
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_BASE_CUTOFF:  prdata = DATA_W'(base_cutoff_reg);
            REG_CROSS_CUTOFF: prdata = DATA_W'(cross_cutoff_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cutoff_reg  <= CUTOFF_RESET;
            cross_cutoff_reg <= CUTOFF_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_BASE_CUTOFF:  base_cutoff_reg  <= pwdata[CUT_W-1:0];
                REG_CROSS_CUTOFF: cross_cutoff_reg <= pwdata[CUT_W-1:0];
                default:          ;
            endcase
        end
    end

    // The front end expands symbols and queues the patterns.
    crc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .symbol  (symbol),
        .full    (full),
        .mid     (mid),
        .mid_pop (mid_pop)
    );

    // The back end owns the run counters, failure counts and peaks.
    crc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_cutoff  (base_cutoff_reg),
        .cross_cutoff (cross_cutoff_reg),
        .mid          (mid),
        .mid_pop      (mid_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res          (res)
    );

    // Finished results wait here until the consumer takes them.
    crc_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign pass                 = head.pass;
    assign fail_mask            = head.fail_mask;
    assign literal_fail_count   = head.literal_fail_count;
    assign cross_fail_count     = head.cross_fail_count;
    assign max_literal_failures = head.max_literal_failures;
    assign max_cross_failures   = head.max_cross_failures;

    // A result passes exactly when no test flagged a failure.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pass == (fail_mask == '0)))
    else $error("pass disagrees with fail_mask");

    // The literal count must match the literal part of the mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(literal_fail_count) == $countones(fail_mask[LITERAL_TESTS-1:0])))
    else $error("literal_fail_count disagrees with fail_mask");

    // The running maxima never fall below the counts of the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (max_literal_failures >= literal_fail_count
                    && max_cross_failures >= cross_fail_count))
    else $error("peak below current failure count");

    // Across consecutive results the running maxima never decrease.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) ##1 !empty |->
            (max_literal_failures >= $past(max_literal_failures)
             && max_cross_failures >= $past(max_cross_failures)))
    else $error("running maximum decreased");

endmodule : crosswise_repetition_count_test

`default_nettype wire

### sv/crc_front.sv
// ============================================================================
// crc_front
// Accepts symbols, expands each into its test pattern and holds the
// patterns in a two-entry queue for the back end.
// ============================================================================
`default_nettype none

module crc_front
    import crc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [SYM_W-1:0] symbol,
    output logic                  full,
    output mid_t                  mid,
    input  wire logic             mid_pop
);

    pattern_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full        = (count_reg == 2'd2);
    assign do_push     = push && !full;
    assign do_pop      = mid_pop && (count_reg != 2'd0);
    assign mid.valid   = (count_reg != 2'd0);
    assign mid.pattern = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= expand(symbol);
        end
    end

endmodule : crc_front

`default_nettype wire

### sv/crc_back.sv
// ============================================================================
// crc_back
// Run length counters and the two result stages: the first updates the
// runs and forms the fail vector, the second counts failures and tracks
// the peaks.
// ============================================================================
`default_nettype none

module crc_back
    import crc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CUT_W-1:0] base_cutoff,
    input  wire logic [CUT_W-1:0] cross_cutoff,
    input  wire mid_t             mid,
    output logic                  mid_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output result_t               res
);

    logic [RUN_WIDTH-1:0]   run_reg  [TEST_COUNT];
    logic [RUN_WIDTH-1:0]   run_next [TEST_COUNT];
    pattern_t               last_reg;
    logic                   seen_first_reg;
    pattern_t               fail_next;
    pattern_t               fail_reg;
    logic                   b_valid_reg;
    logic                   b_valid_next;
    logic [CROSS_SUM_W-1:0] peak_cross_reg;
    logic [CROSS_SUM_W-1:0] peak_cross_next;
    logic [LIT_CNT_W-1:0]   peak_lit_reg;
    logic [LIT_CNT_W-1:0]   peak_lit_next;
    logic                   a_take;
    logic                   b_adv;
    pattern_t               diff;
    logic [RUN_WIDTH-1:0]   run_inc;
    logic [CUT_W-1:0]       cut;
    logic [8*NUM_BYTES-1:0] fail_pad;
    logic [LIT_CNT_W-1:0]   lit_cnt;
    logic [CROSS_SUM_W-1:0] cross_cnt;

    assign b_adv    = b_valid_reg && !res_full;
    assign a_take   = mid.valid && (!b_valid_reg || b_adv);
    assign mid_pop  = a_take;
    assign res_push = b_adv;

    // Stage A: run update and fail vector.
    always_comb
    begin
        diff      = mid.pattern ^ last_reg;
        fail_next = '0;
        run_inc   = '0;
        cut       = '0;
        for (int j = 0; j < TEST_COUNT; j++)
        begin
            cut     = (j < LITERAL_TESTS) ? base_cutoff : cross_cutoff;
            run_inc = (run_reg[j] == RUN_MAX) ? run_reg[j] : run_reg[j] + RUN_ONE;
            if (!seen_first_reg || diff[j])
            begin
                run_next[j] = RUN_ONE;
            end
            else
            begin
                run_next[j]  = run_inc;
                fail_next[j] = (CMP_W'(run_inc) >= CMP_W'(cut));
            end
        end
    end

    // Stage B: failure counts and peaks.
    always_comb
    begin
        fail_pad  = (8*NUM_BYTES)'(fail_reg);
        lit_cnt   = popcount8(fail_pad[7:0]);
        cross_cnt = '0;
        for (int k = 1; k < NUM_BYTES; k++)
        begin
            cross_cnt = cross_cnt + CROSS_SUM_W'(popcount8(fail_pad[8*k +: 8]));
        end
        peak_lit_next   = (lit_cnt > peak_lit_reg) ? lit_cnt : peak_lit_reg;
        peak_cross_next = (cross_cnt > peak_cross_reg) ? cross_cnt : peak_cross_reg;
        b_valid_next    = a_take ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);

        res.pass      = (fail_reg == '0);
        res.fail_mask = '0;
        for (int j = 0; j < MASK_W; j++)
        begin
            if (j < TEST_COUNT)
            begin
                res.fail_mask[j] = fail_pad[j];
            end
        end
        res.literal_fail_count   = lit_cnt;
        res.cross_fail_count     = CROSS_CNT_W'(cross_cnt);
        res.max_literal_failures = peak_lit_next;
        res.max_cross_failures   = CROSS_CNT_W'(peak_cross_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TEST_COUNT; j++)
            begin
                run_reg[j] <= RUN_ONE;
            end
            last_reg       <= '0;
            seen_first_reg <= 1'b0;
            b_valid_reg    <= 1'b0;
            peak_lit_reg   <= '0;
            peak_cross_reg <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            if (a_take)
            begin
                for (int j = 0; j < TEST_COUNT; j++)
                begin
                    run_reg[j] <= run_next[j];
                end
                last_reg       <= mid.pattern;
                seen_first_reg <= 1'b1;
            end
            if (b_adv)
            begin
                peak_lit_reg   <= peak_lit_next;
                peak_cross_reg <= peak_cross_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            fail_reg <= fail_next;
        end
    end

endmodule : crc_back

`default_nettype wire

### sv/crc_result_q.sv
// ============================================================================
// crc_result_q
// Two-entry result queue that drives the result ports.
// ============================================================================
`default_nettype none

module crc_result_q
    import crc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_push,
    input  wire result_t res,
    output logic         res_full,
    output logic         empty,
    input  wire logic    pop,
    output result_t      head
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule : crc_result_q

`default_nettype wire
